>>> rtl/tdtb_pkg.sv
// ----------------------------------------------------------------------------
// tdtb_pkg
// Shared types and constants of the tick divided timer bank.
// ----------------------------------------------------------------------------
package tdtb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int DATA_W     = 32;
  localparam int BIT_CNT_W  = $clog2(DATA_W);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_STOP    = 2'd2,
    OP_SERVICE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_SCAN,
    ST_TICK_DIV,
    ST_TICK_OUT,
    ST_SVC_SCAN
  } state_e;

  typedef struct packed {
    logic                fired;
    logic [2:0]          fired_slot;
    logic [DATA_W-1:0]   elapsed;
    logic                auto_stopped;
    logic                any_due;
    logic                last;
  } result_t;

endpackage

>>> rtl/tdtb_in_if.sv
// ----------------------------------------------------------------------------
// tdtb_in_if
// Input channel of the timer bank: operation and its operands.
// ----------------------------------------------------------------------------
interface tdtb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [2:0]  slot;
  logic [31:0] divisor;
  logic [31:0] total_ticks;

  modport source (output valid, operation, slot, divisor, total_ticks, input ready);
  modport sink   (input valid, operation, slot, divisor, total_ticks, output ready);
  modport mon    (input valid, ready, operation, slot, divisor, total_ticks);
endinterface

>>> rtl/tdtb_out_if.sv
// ----------------------------------------------------------------------------
// tdtb_out_if
// Result channel of the timer bank.
// ----------------------------------------------------------------------------
interface tdtb_out_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [2:0]  fired_slot;
  logic [31:0] elapsed;
  logic        auto_stopped;
  logic        any_due;
  logic        last;

  modport source (output valid, fired, fired_slot, elapsed, auto_stopped, any_due, last,
                  input ready);
  modport sink   (input valid, fired, fired_slot, elapsed, auto_stopped, any_due, last,
                  output ready);
  modport mon    (input valid, ready, fired, fired_slot, elapsed, auto_stopped, any_due,
                  last);
endinterface

>>> rtl/tick_divided_timer_bank_core.sv
// ----------------------------------------------------------------------------
// tick_divided_timer_bank_core
// Bank of periodic timer slots driven by a frame tick, with one shared
// restoring modulo unit that walks the active slots on every tick.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_i    | in  | valid/ready   | operation, slot, divisor, total_ticks
//  out_o   | out | valid/ready   | fired, fired_slot, elapsed, auto_stopped,
//          |     |               | any_due, last
//
//  Start and stop are taken in the idle state and leave the sequencer idle.
//  A tick scans every slot in turn and runs the bit-serial modulo for each
//  active slot, then waits for the output register to take its result.
//  Service scans every slot and can stall on the output at each pending one.
//  Reset clears the counter and all active and pending flags.
//  A result waits in the output register; the sequencer stalls only when it
//  needs that register again.
// ----------------------------------------------------------------------------
module tick_divided_timer_bank_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdtb_in_if.sink   in_i,
  tdtb_out_if.source out_o
);

  localparam int SW = tdtb_pkg::SLOT_W;
  localparam int DW = tdtb_pkg::DATA_W;
  localparam int NT = tdtb_pkg::NUM_TIMERS;
  localparam int BW = tdtb_pkg::BIT_CNT_W;

  tdtb_pkg::state_e state_q, state_d;

  logic [DW-1:0] tick_q, tick_d;
  logic [NT-1:0] active_q, active_d;
  logic [NT-1:0] pending_q, pending_d;
  logic [DW-1:0] div_mem [NT];
  logic [DW-1:0] lim_mem [NT];
  logic [DW-1:0] stamp_mem [NT];

  logic [SW-1:0] idx_q, idx_d;
  logic          due_q, due_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [BW-1:0] bit_q, bit_d;

  logic                  out_valid_q, out_valid_d;
  tdtb_pkg::result_t     res_q, res_d;

  logic          in_acc, out_free, idx_last, slot_ok, mem_wr;
  logic [DW-1:0] cur_div, elapsed, sub_v;
  logic [DW:0]   shift_v;
  logic          ge_v, autos, later_pending;
  logic [NT-1:0] later_mask;
  tdtb_pkg::op_e op;

  assign op       = tdtb_pkg::op_e'(in_i.operation);
  assign in_i.ready = (state_q == tdtb_pkg::ST_IDLE);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign idx_last = (int'(idx_q) == NT - 1);
  assign slot_ok  = (int'(in_i.slot) < NT);
  assign mem_wr   = in_acc && (op == tdtb_pkg::OP_START) && slot_ok;

  assign cur_div  = (div_mem[idx_q] == '0) ? DW'(1) : div_mem[idx_q];
  assign shift_v  = {rem_q, dvd_q[DW-1]};
  assign ge_v     = (shift_v >= {1'b0, cur_div});
  assign sub_v    = DW'(shift_v - {1'b0, cur_div});
  assign elapsed  = tick_q - stamp_mem[idx_q];
  assign autos    = (lim_mem[idx_q] != '0) && (elapsed >= lim_mem[idx_q]);

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      later_mask[i] = (i > int'(idx_q));
    end
  end
  assign later_pending = |(pending_q & later_mask);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdtb_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (op)
            tdtb_pkg::OP_TICK:    state_d = tdtb_pkg::ST_TICK_SCAN;
            tdtb_pkg::OP_SERVICE: state_d = tdtb_pkg::ST_SVC_SCAN;
            default:              state_d = tdtb_pkg::ST_IDLE;
          endcase
        end
      end
      tdtb_pkg::ST_TICK_SCAN: begin
        if (active_q[idx_q]) begin
          state_d = tdtb_pkg::ST_TICK_DIV;
        end else if (idx_last) begin
          state_d = tdtb_pkg::ST_TICK_OUT;
        end
      end
      tdtb_pkg::ST_TICK_DIV: begin
        if (bit_q == '1) begin
          state_d = idx_last ? tdtb_pkg::ST_TICK_OUT : tdtb_pkg::ST_TICK_SCAN;
        end
      end
      tdtb_pkg::ST_TICK_OUT: begin
        if (out_free) begin
          state_d = tdtb_pkg::ST_IDLE;
        end
      end
      tdtb_pkg::ST_SVC_SCAN: begin
        if (idx_last && (!pending_q[idx_q] || out_free)) begin
          state_d = tdtb_pkg::ST_IDLE;
        end
      end
      default: state_d = tdtb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    tick_d      = tick_q;
    active_d    = active_q;
    pending_d   = pending_q;
    idx_d       = idx_q;
    due_d       = due_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;
    unique case (state_q)
      tdtb_pkg::ST_IDLE: begin
        idx_d = '0;
        due_d = 1'b0;
        if (in_acc) begin
          unique case (op)
            tdtb_pkg::OP_TICK: tick_d = tick_q + DW'(1);
            tdtb_pkg::OP_START: begin
              if (slot_ok) begin
                active_d[SW'(in_i.slot)]  = 1'b1;
                pending_d[SW'(in_i.slot)] = 1'b0;
              end
            end
            tdtb_pkg::OP_STOP: begin
              if (slot_ok) begin
                active_d[SW'(in_i.slot)]  = 1'b0;
                pending_d[SW'(in_i.slot)] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      tdtb_pkg::ST_TICK_SCAN: begin
        rem_d = '0;
        dvd_d = tick_q;
        bit_d = '0;
        if (!active_q[idx_q] && !idx_last) begin
          idx_d = idx_q + SW'(1);
        end
      end
      tdtb_pkg::ST_TICK_DIV: begin
        rem_d = ge_v ? sub_v : shift_v[DW-1:0];
        dvd_d = {dvd_q[DW-2:0], 1'b0};
        bit_d = bit_q + BW'(1);
        if (bit_q == '1) begin
          if ((ge_v ? sub_v : shift_v[DW-1:0]) == '0) begin
            pending_d[idx_q] = 1'b1;
            due_d            = 1'b1;
          end
          if (!idx_last) begin
            idx_d = idx_q + SW'(1);
          end
        end
      end
      tdtb_pkg::ST_TICK_OUT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          res_d              = '0;
          res_d.any_due      = due_q;
          res_d.last         = 1'b1;
        end
      end
      tdtb_pkg::ST_SVC_SCAN: begin
        if (!pending_q[idx_q] || out_free) begin
          if (!idx_last) begin
            idx_d = idx_q + SW'(1);
          end
          if (pending_q[idx_q]) begin
            pending_d[idx_q]   = 1'b0;
            if (autos) begin
              active_d[idx_q]  = 1'b0;
            end
            out_valid_d        = 1'b1;
            res_d.fired        = 1'b1;
            res_d.fired_slot   = 3'(idx_q);
            res_d.elapsed      = elapsed;
            res_d.auto_stopped = autos;
            res_d.any_due      = 1'b0;
            res_d.last         = !later_pending;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdtb_pkg::ST_IDLE;
      tick_q      <= '0;
      active_q    <= '0;
      pending_q   <= '0;
      idx_q       <= '0;
      due_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      active_q    <= active_d;
      pending_q   <= pending_d;
      idx_q       <= idx_d;
      due_q       <= due_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    bit_q <= bit_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      div_mem[SW'(in_i.slot)]   <= (in_i.divisor == '0) ? DW'(1) : in_i.divisor;
      lim_mem[SW'(in_i.slot)]   <= in_i.total_ticks;
      stamp_mem[SW'(in_i.slot)] <= tick_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.fired        = res_q.fired;
  assign out_o.fired_slot   = res_q.fired_slot;
  assign out_o.elapsed      = res_q.elapsed;
  assign out_o.auto_stopped = res_q.auto_stopped;
  assign out_o.any_due      = res_q.any_due;
  assign out_o.last         = res_q.last;

endmodule

>>> rtl/tdtb_checker.sv
// ----------------------------------------------------------------------------
// tdtb_checker
// Port level checks of the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module tdtb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_operation_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_fired_i,
  input logic [31:0] out_elapsed_i,
  input logic        out_auto_stopped_i,
  input logic        out_any_due_i,
  input logic        out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_elapsed_i))
    else $error("result dropped or changed while stalled");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_operation_i == tdtb_pkg::OP_TICK) |=> !in_ready_i)
    else $error("tick item did not occupy the sequencer");

  a_tick_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_any_due_i |-> out_last_i && !out_fired_i && !out_auto_stopped_i)
    else $error("tick result has service fields set");

  a_svc_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_fired_i |-> out_last_i && (out_elapsed_i == '0))
    else $error("non service result malformed");

endmodule

bind tick_divided_timer_bank_core tdtb_checker u_tdtb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_operation_i    (in_i.operation),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_fired_i       (out_o.fired),
  .out_elapsed_i     (out_o.elapsed),
  .out_auto_stopped_i(out_o.auto_stopped),
  .out_any_due_i     (out_o.any_due),
  .out_last_i        (out_o.last)
);
